FILE: src/ffba_pkg.sv
// shared types, constants and helpers of the first-fit block allocator
package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int OFF_W = $clog2(MAX_BLOCKS * (65535 + HEADER_BYTES) + 1);

   localparam logic [15:0] POOL_RESET = 16'hFFFF;

   localparam logic [0:0] KIND_ALLOC = 1'b0;
   localparam logic [0:0] KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [15:0] size;
      logic        free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // saturating a + b + header
   function automatic logic [15:0] merge_size(input logic [15:0] a, input logic [15:0] b);
      logic [17:0] sum;
      sum = {2'b00, a} + {2'b00, b} + 18'(HEADER_BYTES);
      merge_size = (sum > 18'h0FFFF) ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

FILE: src/ffba_req_if.sv
// request channel: allocate or free item
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  kind;
   logic [15:0] request_bytes;
   logic [15:0] free_address;

   modport source (output valid, kind, request_bytes, free_address, input ready);
   modport sink   (input valid, kind, request_bytes, free_address, output ready);
endinterface

FILE: src/ffba_rsp_if.sv
// response channel: status item
interface ffba_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

FILE: src/ffba_ram.sv
// generic simple dual-port ram with registered read
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: src/first_fit_block_allocator_unit.sv
// first-fit block allocator: block table in ram, scan / shift / merge sequencer
// allocate: scan entries for the first fit, shift later entries right on a split, insert the rest;
//   free: scan for the address, read the right neighbor, merge, shift later entries left
// one item at a time: a request is taken only in the idle state
// reset: pool 65535, one free block; the init state writes table entry 0 after reset
module first_fit_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   ffba_req_if.sink    req_if,
   ffba_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   localparam int H = ffba_pkg::HEADER_BYTES;

   // sequencer codes
   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_RD      = 4'd2;
   localparam logic [3:0] S_CHK     = 4'd3;
   localparam logic [3:0] S_NXT_RD  = 4'd4;
   localparam logic [3:0] S_NXT_CHK = 4'd5;
   localparam logic [3:0] S_MERGE   = 4'd6;
   localparam logic [3:0] S_SHR_RD  = 4'd7;
   localparam logic [3:0] S_SHR_WR  = 4'd8;
   localparam logic [3:0] S_INS     = 4'd9;
   localparam logic [3:0] S_SHL_RD  = 4'd10;
   localparam logic [3:0] S_SHL_WR  = 4'd11;
   localparam logic [3:0] S_FIN     = 4'd12;
   localparam logic [3:0] S_DONE    = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [15:0] pool_ff, pool_in;
   logic [ffba_pkg::CNT_W-1:0] count_ff, count_in;
   logic [15:0] now_ff, now_in;
   logic [15:0] peak_ff, peak_in;

   // per item working registers
   logic [0:0]  kind_ff, kind_in;
   logic [15:0] req_ff, req_in;
   logic [15:0] addr_ff, addr_in;
   logic [ffba_pkg::CNT_W-1:0] i_ff, i_in;
   logic [ffba_pkg::CNT_W-1:0] j_ff, j_in;
   logic [1:0]  gap_ff, gap_in;
   logic [ffba_pkg::OFF_W-1:0] off_ff, off_in;
   logic        pf_ff, pf_in;
   logic [15:0] ps_ff, ps_in;
   logic        nf_ff, nf_in;
   logic [15:0] ns_ff, ns_in;
   logic [15:0] cs_ff, cs_in;
   logic [15:0] rest_ff, rest_in;
   logic [1:0]  status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // ram port
   logic                       we;
   logic [ffba_pkg::IDX_W-1:0] waddr, raddr;
   ffba_pkg::entry_type        wdata, rdata;

   ffba_ram #(.WIDTH(ffba_pkg::ENTRY_W), .DEPTH(ffba_pkg::MAX_BLOCKS)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // scratch
   logic [16:0] need;
   logic        split;
   logic [16:0] usage_sum;
   logic [15:0] give;
   logic [15:0] merged;
   logic [ffba_pkg::CNT_W-1:0] i_next;

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      pool_in       = pool_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      peak_in       = peak_ff;
      kind_in       = kind_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      gap_in        = gap_ff;
      off_in        = off_ff;
      pf_in         = pf_ff;
      ps_in         = ps_ff;
      nf_in         = nf_ff;
      ns_in         = ns_ff;
      cs_in         = cs_ff;
      rest_in       = rest_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      raddr         = i_ff[ffba_pkg::IDX_W-1:0];
      need          = {1'b0, req_ff} + 17'(H);
      split         = ({1'b0, rdata.size} > need) &&
                      (count_ff < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
      give          = split ? req_ff : rdata.size;
      usage_sum     = {1'b0, now_ff} + {1'b0, give};
      merged        = '0;
      i_next        = i_ff + 1'b1;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // lay down the single free block
            we      = 1'b1;
            waddr   = '0;
            wdata.size = (pool_ff > 16'(H)) ? pool_ff - 16'(H) : 16'd0;
            wdata.free = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in  = req_if.kind;
               req_in   = req_if.request_bytes;
               addr_in  = req_if.free_address;
               i_in     = '0;
               off_in   = ffba_pkg::OFF_W'(H);
               pf_in    = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            raddr    = i_ff[ffba_pkg::IDX_W-1:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (kind_ff == ffba_pkg::KIND_ALLOC) begin
               if (rdata.free && (rdata.size >= req_ff)) begin
                  // first fit found: claim it, maybe split the rest off
                  we         = 1'b1;
                  waddr      = i_ff[ffba_pkg::IDX_W-1:0];
                  wdata.size = give;
                  wdata.free = 1'b0;
                  now_in     = usage_sum[16] ? 16'hFFFF : usage_sum[15:0];
                  if (now_in > peak_ff) begin
                     peak_in = now_in;
                  end
                  status_in  = ffba_pkg::ST_OK;
                  if (split) begin
                     rest_in = rdata.size - req_ff - 16'(H);
                     j_in    = count_ff - 1'b1;
                     state_in = (count_ff - 1'b1 > i_ff) ? S_SHR_RD : S_INS;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (i_next == count_ff) begin
                  status_in = ffba_pkg::ST_NO_FIT;
                  state_in  = S_DONE;
               end else begin
                  i_in     = i_next;
                  state_in = S_RD;
               end
            end else begin
               if (off_ff == ffba_pkg::OFF_W'(addr_ff)) begin
                  if (rdata.free) begin
                     status_in = ffba_pkg::ST_BAD_FREE;
                     state_in  = S_DONE;
                  end else begin
                     cs_in     = rdata.size;
                     now_in    = (now_ff > rdata.size) ? now_ff - rdata.size : 16'd0;
                     status_in = ffba_pkg::ST_OK;
                     nf_in     = 1'b0;
                     state_in  = (i_next < count_ff) ? S_NXT_RD : S_MERGE;
                  end
               end else if (i_next == count_ff) begin
                  status_in = ffba_pkg::ST_BAD_FREE;
                  state_in  = S_DONE;
               end else begin
                  // walk the address and remember this block as the left neighbor
                  off_in   = off_ff + ffba_pkg::OFF_W'(rdata.size) + ffba_pkg::OFF_W'(H);
                  pf_in    = rdata.free;
                  ps_in    = rdata.size;
                  i_in     = i_next;
                  state_in = S_RD;
               end
            end
         end
         S_NXT_RD: begin
            raddr    = i_next[ffba_pkg::IDX_W-1:0];
            state_in = S_NXT_CHK;
         end
         S_NXT_CHK: begin
            nf_in    = rdata.free;
            ns_in    = rdata.size;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            // only the neighbors of the freed block can be free
            we         = 1'b1;
            wdata.free = 1'b1;
            if (pf_ff) begin
               merged = ffba_pkg::merge_size(ps_ff, cs_ff);
               if (nf_ff) begin
                  merged = ffba_pkg::merge_size(merged, ns_ff);
               end
               waddr  = i_ff[ffba_pkg::IDX_W-1:0] - 1'b1;
               gap_in = nf_ff ? 2'd2 : 2'd1;
               j_in   = nf_ff ? i_ff + 2'd2 : i_next;
            end else begin
               merged = nf_ff ? ffba_pkg::merge_size(cs_ff, ns_ff) : cs_ff;
               waddr  = i_ff[ffba_pkg::IDX_W-1:0];
               gap_in = nf_ff ? 2'd1 : 2'd0;
               j_in   = i_ff + 2'd2;
            end
            wdata.size = merged;
            if (gap_in == 2'd0) begin
               state_in = S_DONE;
            end else if (j_in < count_ff) begin
               state_in = S_SHL_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SHR_RD: begin
            raddr    = j_ff[ffba_pkg::IDX_W-1:0];
            state_in = S_SHR_WR;
         end
         S_SHR_WR: begin
            we       = 1'b1;
            waddr    = ffba_pkg::IDX_W'(j_ff + 1'b1);
            wdata    = rdata;
            j_in     = j_ff - 1'b1;
            state_in = (j_ff - 1'b1 > i_ff) ? S_SHR_RD : S_INS;
         end
         S_INS: begin
            we         = 1'b1;
            waddr      = i_next[ffba_pkg::IDX_W-1:0];
            wdata.size = rest_ff;
            wdata.free = 1'b1;
            count_in   = count_ff + 1'b1;
            state_in   = S_DONE;
         end
         S_SHL_RD: begin
            raddr    = j_ff[ffba_pkg::IDX_W-1:0];
            state_in = S_SHL_WR;
         end
         S_SHL_WR: begin
            we       = 1'b1;
            waddr    = ffba_pkg::IDX_W'(j_ff - ffba_pkg::CNT_W'(gap_ff));
            wdata    = rdata;
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 < count_ff) ? S_SHL_RD : S_FIN;
         end
         S_FIN: begin
            count_in = count_ff - ffba_pkg::CNT_W'(gap_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      // pool write rebuilds the table; the user must write it only while idle, the block does not enforce it
      if (csr_we) begin
         pool_in    = csr_wdata;
         count_in   = ffba_pkg::CNT_W'(1);
         now_in     = '0;
         peak_in    = '0;
         we         = 1'b1;
         waddr      = '0;
         wdata.size = (csr_wdata > 16'(H)) ? csr_wdata - 16'(H) : 16'd0;
         wdata.free = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= ffba_pkg::POOL_RESET;
         count_ff     <= ffba_pkg::CNT_W'(1);
         now_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      gap_ff        <= gap_in;
      off_ff        <= off_in;
      pf_ff         <= pf_in;
      ps_ff         <= ps_in;
      nf_ff         <= nf_in;
      ns_ff         <= ns_in;
      cs_ff         <= cs_in;
      rest_ff       <= rest_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule

FILE: test/first_fit_block_allocator_unit_tb.sv
// testbench of the first-fit block allocator: predicted status checked item by item
module first_fit_block_allocator_unit_tb;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   ffba_req_if req_if ();
   ffba_rsp_if rsp_if ();

   first_fit_block_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state: block table, pool size and usage
   logic [15:0] pool_size;
   logic [15:0] blk_size [ffba_pkg::MAX_BLOCKS];
   logic        blk_free [ffba_pkg::MAX_BLOCKS];
   int          blk_count;
   logic [15:0] used_bytes;
   logic [15:0] peak_bytes;

   logic [1:0]  status_queue [$];
   int          mismatch_count;
   int          stall_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          result_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // fresh table holding one free block
   task automatic table_init();
      for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++) begin
         blk_size[i] = '0;
         blk_free[i] = 1'b0;
      end
      blk_size[0] = (pool_size > ffba_pkg::HEADER_BYTES) ?
                    pool_size - 16'(ffba_pkg::HEADER_BYTES) : 16'd0;
      blk_free[0] = 1'b1;
      blk_count   = 1;
      used_bytes  = '0;
      peak_bytes  = '0;
   endtask

   function automatic void drop_entry(input int at);
      for (int i = at; i + 1 < blk_count; i++) begin
         blk_size[i] = blk_size[i + 1];
         blk_free[i] = blk_free[i + 1];
      end
      blk_count--;
      blk_size[blk_count] = '0;
      blk_free[blk_count] = 1'b0;
   endfunction

   function automatic logic [1:0] predict_alloc(input logic [15:0] req);
      int unsigned rest;
      int unsigned tot;
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_size[i] >= req) begin
            // split only when remainder beats a header and the table has room
            if (int'(blk_size[i]) > int'(req) + ffba_pkg::HEADER_BYTES &&
                blk_count < ffba_pkg::MAX_BLOCKS) begin
               rest = blk_size[i] - req - ffba_pkg::HEADER_BYTES;
               for (int j = blk_count; j > i + 1; j--) begin
                  blk_size[j] = blk_size[j - 1];
                  blk_free[j] = blk_free[j - 1];
               end
               blk_size[i]     = req;
               blk_size[i + 1] = 16'(rest);
               blk_free[i + 1] = 1'b1;
               blk_count++;
            end
            blk_free[i] = 1'b0;
            tot = used_bytes + blk_size[i];
            used_bytes = (tot > 65535) ? 16'hFFFF : 16'(tot);
            if (used_bytes > peak_bytes) peak_bytes = used_bytes;
            return ffba_pkg::ST_OK;
         end
      end
      return ffba_pkg::ST_NO_FIT;
   endfunction

   function automatic logic [1:0] predict_free(input logic [15:0] addr);
      int unsigned offs;
      int          k;
      int unsigned sum;
      offs = ffba_pkg::HEADER_BYTES;
      for (int i = 0; i < blk_count; i++) begin
         if (offs == addr) begin
            if (blk_free[i]) return ffba_pkg::ST_BAD_FREE;
            blk_free[i] = 1'b1;
            used_bytes = (used_bytes > blk_size[i]) ? used_bytes - blk_size[i] : 16'd0;
            // merge every run of adjacent free blocks
            k = 0;
            while (k + 1 < blk_count) begin
               if (blk_free[k] && blk_free[k + 1]) begin
                  sum = blk_size[k] + blk_size[k + 1] + ffba_pkg::HEADER_BYTES;
                  blk_size[k] = (sum > 65535) ? 16'hFFFF : 16'(sum);
                  drop_entry(k + 1);
               end else begin
                  k++;
               end
            end
            return ffba_pkg::ST_OK;
         end
         offs += blk_size[i] + ffba_pkg::HEADER_BYTES;
      end
      return ffba_pkg::ST_BAD_FREE;
   endfunction

   // payload offset of the given block, or a bad value if it is past the end
   function automatic logic [15:0] block_offset(input int idx);
      int unsigned offs;
      offs = ffba_pkg::HEADER_BYTES;
      for (int i = 0; i < idx; i++) offs += blk_size[i] + ffba_pkg::HEADER_BYTES;
      return 16'(offs);
   endfunction

   // send one item, predict its status once accepted
   task automatic send_item(input logic [0:0] kind, input logic [15:0] req,
                            input logic [15:0] addr);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_if.valid         <= 1'b1;
      req_if.kind          <= kind;
      req_if.request_bytes <= req;
      req_if.free_address  <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (kind == ffba_pkg::KIND_ALLOC) status_queue.push_back(predict_alloc(req));
      else                              status_queue.push_back(predict_free(addr));
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for all pending results, then let the block settle
   task automatic drain();
      while (status_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_pool(input logic [15:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      pool_size = value;
      table_init();
      @(posedge clock);
   endtask

   // receiver: random ready and the status check
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (status_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected status %0d", rsp_if.status);
            end else if (rsp_if.status !== status_queue[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("status mismatch: expected %0d actual %0d",
                           status_queue[0], rsp_if.status);
               void'(status_queue.pop_front());
            end else begin
               void'(status_queue.pop_front());
            end
         end
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count > 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // directed: field extremes, small pool, zero-byte request, bad frees
   task automatic test_directed();
      send_item(ffba_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);
      send_item(ffba_pkg::KIND_ALLOC, 16'd100, 16'd0);
      send_item(ffba_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
      send_item(ffba_pkg::KIND_FREE, 16'hFFFF, 16'd0);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'd16);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'd16);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'hFFFF);
      send_item(ffba_pkg::KIND_FREE, 16'd0, block_offset(1));
      send_item(ffba_pkg::KIND_ALLOC, 16'd65519, 16'd0);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'd16);
      write_pool(16'd64);
      send_item(ffba_pkg::KIND_ALLOC, 16'd48, 16'd0);
      send_item(ffba_pkg::KIND_ALLOC, 16'd0, 16'd0);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'd16);
      write_pool(16'd16);
      send_item(ffba_pkg::KIND_ALLOC, 16'd0, 16'd0);
      send_item(ffba_pkg::KIND_ALLOC, 16'd0, 16'd0);
      send_item(ffba_pkg::KIND_FREE, 16'd0, 16'd16);
   endtask

   // table-full: many tiny allocations, then frees of random block offsets
   task automatic test_table_full();
      write_pool(16'd4000);
      for (int i = 0; i < 70; i++)
         send_item(ffba_pkg::KIND_ALLOC, 16'($urandom_range(8)), 16'd0);
      for (int i = 0; i < 64; i++)
         send_item(ffba_pkg::KIND_FREE, 16'($urandom),
                   block_offset($urandom_range(blk_count - 1)));
   endtask

   // random mix: allocations, frees of real block offsets and some noise frees at random addresses
   task automatic test_random(input int n);
      int pick;
      logic [15:0] req;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            req = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(pool_size / 8));
            send_item(ffba_pkg::KIND_ALLOC, req, 16'($urandom));
         end else if (pick < 90) begin
            send_item(ffba_pkg::KIND_FREE, 16'($urandom),
                      block_offset($urandom_range(blk_count - 1)));
         end else begin
            send_item(ffba_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic test_idle_mix();
      send_idle_pct = 15;
      recv_idle_pct = 45;
      write_pool(16'd65535);
      test_random(250);
      write_pool(16'($urandom_range(64, 2000)));
      test_random(250);
      send_idle_pct = 45;
      recv_idle_pct = 15;
      write_pool(16'($urandom_range(2000, 65535)));
      test_random(250);
      write_pool(16'd64);
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_pool(16'd1500);
      test_random(300);
      write_pool(16'($urandom));
      test_random(250);
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.kind    = ffba_pkg::KIND_ALLOC;
      req_if.request_bytes = '0;
      req_if.free_address  = '0;
      mismatch_count = 0;
      stall_count    = 0;
      result_count   = 0;
      send_idle_pct  = 15;
      recv_idle_pct  = 45;
      pool_size      = ffba_pkg::POOL_RESET;
      table_init();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_directed();
      test_table_full();
      test_idle_mix();

      drain();
      if (mismatch_count == 0 && status_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
